### hdl/rpcc_pkg.sv
// Shared constants, types and CRC step for the receive packet checker.
package rpcc_pkg;

   // Packet geometry
   localparam int DATA_BYTES = 246;
   localparam int PKT_BYTES  = DATA_BYTES + 10;
   localparam int POS_W      = $clog2(PKT_BYTES);
   localparam int HDR_BYTES  = 8;

   // Byte positions within the packet
   localparam logic [POS_W-1:0] POS_DIR      = POS_W'(0);
   localparam logic [POS_W-1:0] POS_DEV      = POS_W'(1);
   localparam logic [POS_W-1:0] POS_REM_LO   = POS_W'(4);
   localparam logic [POS_W-1:0] POS_REM_HI   = POS_W'(5);
   localparam logic [POS_W-1:0] POS_PLEN_LO  = POS_W'(6);
   localparam logic [POS_W-1:0] POS_PLEN_HI  = POS_W'(7);
   localparam logic [POS_W-1:0] POS_DATA     = POS_W'(8);
   localparam logic [POS_W-1:0] POS_PCRC_LO  = POS_W'(PKT_BYTES - 2);
   localparam logic [POS_W-1:0] POS_LAST     = POS_W'(PKT_BYTES - 1);

   // Offsets within the data area (message header)
   localparam logic [POS_W-1:0] OFS_TYPE_LO  = POS_W'(0);
   localparam logic [POS_W-1:0] OFS_TYPE_HI  = POS_W'(1);
   localparam logic [POS_W-1:0] OFS_LEN_LO   = POS_W'(6);
   localparam logic [POS_W-1:0] OFS_LEN_HI   = POS_W'(7);

   // Header values
   localparam logic [7:0]  DIR_REPLY      = 8'h40;
   localparam logic [7:0]  DEV_KEYBOARD   = 8'h01;
   localparam logic [7:0]  DEV_TRACKPAD   = 8'h02;
   localparam logic [7:0]  DEV_SYSINFO    = 8'hD0;
   localparam logic [15:0] TYPE_KBD       = 16'h0110;
   localparam logic [15:0] TYPE_BACKLIGHT = 16'hB051;
   localparam logic [15:0] TYPE_MT_ENABLE = 16'h0252;
   localparam logic [15:0] TYPE_TOUCH     = 16'h0210;
   localparam logic [15:0] TYPE_INFO      = 16'h1020;
   localparam logic [15:0] KBD_PAYLOAD    = 16'd10;
   localparam logic [15:0] CRC_POLY_REFL  = 16'hA001;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_PKT_CRC   = 3'd1,
      ST_MULTI     = 3'd2,
      ST_TOO_LONG  = 3'd3,
      ST_MSG_CRC   = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      KIND_KBD_REPORT    = 4'd0,
      KIND_KBD_BACKLIGHT = 4'd1,
      KIND_KBD_BAD_TYPE  = 4'd2,
      KIND_KBD_BAD_LEN   = 4'd3,
      KIND_MT_ENABLED    = 4'd4,
      KIND_TOUCH         = 4'd5,
      KIND_TPAD_BAD_TYPE = 4'd6,
      KIND_INFO          = 4'd7,
      KIND_INFO_BAD_TYPE = 4'd8,
      KIND_OTHER         = 4'd9
   } kind_type;

   // Verdict passed from front end to back end
   typedef struct packed {
      status_type  status;
      logic [7:0]  device;
      logic [15:0] msg_type;
      logic [15:0] msg_len;
      logic        reply_done;
   } verdict_type;

   // Reflected CRC-16/ARC over one byte
   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] r;
      r = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY_REFL) : (r >> 1);
      end
      return r;
   endfunction

endpackage

### hdl/rpcc_front.sv
// Front end: per-byte CRC and field capture, verdict at the last byte.
module rpcc_front
   import rpcc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [7:0]  in_byte,
   input  logic        in_first,
   output logic        push,
   output verdict_type push_data,
   input  logic        queue_full
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0] pcrc_ff, pcrc_in;
   logic [15:0] mcrc_ff, mcrc_in;
   logic [7:0]  dir_ff, dir_in;
   logic [7:0]  dev_ff, dev_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] plen_ff, plen_in;
   logic [15:0] type_ff, type_in;
   logic [15:0] hlen_ff, hlen_in;
   logic [15:0] smcrc_ff, smcrc_in;
   logic [7:0]  spcrc_lo_ff, spcrc_lo_in;

   logic             accept;
   logic [POS_W-1:0] pos;
   logic [POS_W-1:0] ofs;
   logic             in_data;
   logic             last;
   logic [15:0]      spcrc;
   status_type       status;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;

   // Next-state computation; a first mark restarts from the cleared state
   always_comb begin
      pos      = in_first ? '0 : pos_ff;
      pcrc_in  = in_first ? '0 : pcrc_ff;
      mcrc_in  = in_first ? '0 : mcrc_ff;
      dir_in   = in_first ? '0 : dir_ff;
      dev_in   = in_first ? '0 : dev_ff;
      rem_in   = in_first ? '0 : rem_ff;
      plen_in  = in_first ? '0 : plen_ff;
      type_in  = in_first ? '0 : type_ff;
      hlen_in  = in_first ? '0 : hlen_ff;
      smcrc_in = in_first ? '0 : smcrc_ff;
      spcrc_lo_in = in_first ? '0 : spcrc_lo_ff;

      ofs     = pos - POS_DATA;
      in_data = (pos >= POS_DATA) && (pos < POS_PCRC_LO);
      last    = (pos == POS_LAST);

      if (pos < POS_PCRC_LO) begin
         pcrc_in = crc16_step(pcrc_in, in_byte);
      end

      // Packet header fields
      case (pos)
         POS_DIR:     dir_in        = in_byte;
         POS_DEV:     dev_in        = in_byte;
         POS_REM_LO:  rem_in[7:0]   = in_byte;
         POS_REM_HI:  rem_in[15:8]  = in_byte;
         POS_PLEN_LO: plen_in[7:0]  = in_byte;
         POS_PLEN_HI: plen_in[15:8] = in_byte;
         default: ;
      endcase

      // Message area: CRC and header capture
      if (in_data) begin
         if (17'(ofs) + 17'd2 < {1'b0, plen_in}) begin
            mcrc_in = crc16_step(mcrc_in, in_byte);
         end
         if (ofs == OFS_TYPE_LO) begin
            type_in[7:0] = in_byte;
         end else if (ofs == OFS_TYPE_HI) begin
            type_in[15:8] = in_byte;
         end else if (ofs == OFS_LEN_LO) begin
            hlen_in[7:0] = in_byte;
         end else if (ofs == OFS_LEN_HI) begin
            hlen_in[15:8] = in_byte;
         end else if (17'(ofs) == {1'b0, hlen_in} + 17'(HDR_BYTES)) begin
            smcrc_in[7:0] = in_byte;
         end else if (17'(ofs) == {1'b0, hlen_in} + 17'(HDR_BYTES + 1)) begin
            smcrc_in[15:8] = in_byte;
         end
      end

      if (pos == POS_PCRC_LO) begin
         spcrc_lo_in = in_byte;
      end

      pos_in = last ? '0 : pos + POS_W'(1);

      // Verdict, in priority order
      spcrc = {in_byte, spcrc_lo_in};
      if (pcrc_in != spcrc) begin
         status = ST_PKT_CRC;
      end else if (rem_in != 16'd0) begin
         status = ST_MULTI;
      end else if ({1'b0, hlen_in} + 17'd10 >= 17'(DATA_BYTES)) begin
         status = ST_TOO_LONG;
      end else if ((plen_in < 16'd2) || ({1'b0, plen_in} > 17'(DATA_BYTES + 2)) ||
                   (smcrc_in != mcrc_in)) begin
         status = ST_MSG_CRC;
      end else begin
         status = ST_OK;
      end
   end

   assign push                 = accept && last;
   assign push_data.status     = status;
   assign push_data.device     = dev_in;
   assign push_data.msg_type   = type_in;
   assign push_data.msg_len    = hlen_in;
   assign push_data.reply_done = (dir_in == DIR_REPLY);

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         pcrc_ff     <= '0;
         mcrc_ff     <= '0;
         dir_ff      <= '0;
         dev_ff      <= '0;
         rem_ff      <= '0;
         plen_ff     <= '0;
         type_ff     <= '0;
         hlen_ff     <= '0;
         smcrc_ff    <= '0;
         spcrc_lo_ff <= '0;
      end else if (accept) begin
         pos_ff      <= pos_in;
         pcrc_ff     <= pcrc_in;
         mcrc_ff     <= mcrc_in;
         dir_ff      <= dir_in;
         dev_ff      <= dev_in;
         rem_ff      <= rem_in;
         plen_ff     <= plen_in;
         type_ff     <= type_in;
         hlen_ff     <= hlen_in;
         smcrc_ff    <= smcrc_in;
         spcrc_lo_ff <= spcrc_lo_in;
      end
   end

endmodule

### hdl/rpcc_queue.sv
// Two-entry verdict queue between front end and back end.
module rpcc_queue
   import rpcc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  verdict_type push_data,
   output logic        full,
   input  logic        pop,
   output logic        head_valid,
   output verdict_type head_data
);

   verdict_type entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_pop;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   // Pointer and count update
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hdl/rpcc_back.sv
// Back end: dispatch kind decode and registered result output.
module rpcc_back
   import rpcc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  verdict_type head_data,
   output logic        pop,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [47:0] out_data
);

   logic        valid_ff, valid_in;
   logic [47:0] data_ff, data_in;
   kind_type    kind;

   // Dispatch kind by device and message type
   always_comb begin
      kind = KIND_OTHER;
      if (head_data.status == ST_OK) begin
         unique case (head_data.device)
            DEV_KEYBOARD: begin
               if (head_data.msg_type == TYPE_BACKLIGHT) begin
                  kind = KIND_KBD_BACKLIGHT;
               end else if (head_data.msg_type != TYPE_KBD) begin
                  kind = KIND_KBD_BAD_TYPE;
               end else if (head_data.msg_len != KBD_PAYLOAD) begin
                  kind = KIND_KBD_BAD_LEN;
               end else begin
                  kind = KIND_KBD_REPORT;
               end
            end
            DEV_TRACKPAD: begin
               if (head_data.msg_type == TYPE_MT_ENABLE) begin
                  kind = KIND_MT_ENABLED;
               end else if (head_data.msg_type == TYPE_TOUCH) begin
                  kind = KIND_TOUCH;
               end else begin
                  kind = KIND_TPAD_BAD_TYPE;
               end
            end
            DEV_SYSINFO: begin
               kind = (head_data.msg_type == TYPE_INFO) ? KIND_INFO : KIND_INFO_BAD_TYPE;
            end
            default: kind = KIND_OTHER;
         endcase
      end
   end

   // Output register loads a queued verdict whenever it is empty or being drained
   assign pop = head_valid && (!valid_ff || out_ready);

   always_comb begin
      valid_in = valid_ff && !out_ready;
      data_in  = data_ff;
      if (pop) begin
         valid_in = 1'b1;
         data_in  = {head_data.reply_done, head_data.msg_len, head_data.msg_type,
                     head_data.device, kind, head_data.status};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### hdl/rx_packet_check_classify.sv
// Top level: receive packet CRC check and message classifier.
// Throughput: one byte per cycle while the verdict queue is not full; one result per packet
// of PKT_BYTES bytes. Each verdict is written into the queue at the edge that accepts the
// packet's last byte, then decoded into the output register once that register is free.
// The two-entry verdict queue holds input ready low only while it is full.
// Reset (synchronous) clears the byte position, both CRCs and all captured fields.
module rx_packet_check_classify
   import rpcc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] first
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // [2:0] status, [6:3] kind, [14:7] device,
                                    // [30:15] msg_type, [46:31] msg_len, [47] reply_done
);

   logic        push;
   verdict_type push_data;
   logic        queue_full;
   logic        pop;
   logic        head_valid;
   verdict_type head_data;

   rpcc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .in_first   (req_tuser),
      .push       (push),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   rpcc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   rpcc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (rsp_tdata)
   );

endmodule

### verif/rx_packet_check_classify_test.sv
// Testbench for rx_packet_check_classify: packet verdicts and dispatch kinds.
module rx_packet_check_classify_test
   import rpcc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // One verdict as it appears on rsp_tdata, lowest field last
   typedef struct packed {
      logic        reply_done;
      logic [15:0] msg_len;
      logic [15:0] msg_type;
      logic [7:0]  device;
      kind_type    kind;
      status_type  status;
   } outcome_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] rx_byte
   logic        req_tuser  = 1'b0;    // [0] first
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;            // [2:0] status, [6:3] kind, [14:7] device,
                                      // [30:15] msg_type, [46:31] msg_len, [47] reply_done

   int idle_pct  = 35;
   int stall_pct = 35;
   int failures  = 0;

   outcome_type expected_verdicts[$];

   // Packet under construction
   logic [7:0] frame [PKT_BYTES];

   // Mirror of the checker state
   int unsigned rx_pos;
   logic [15:0] crc_all, crc_msg;
   logic [7:0]  seen_dir, seen_dev;
   logic [15:0] seen_rem, seen_plen, seen_type, seen_paylen, seen_msg_crc, seen_pkt_crc;

   rx_packet_check_classify i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   // CRC-16/ARC, reflected: feed the byte LSB first
   function automatic logic [15:0] crc16_arc_byte(input logic [15:0] c, input logic [7:0] b);
      logic fb;
      for (int i = 0; i < 8; i++) begin
         fb = c[0] ^ b[i];
         c  = c >> 1;
         if (fb) c = c ^ 16'hA001;
      end
      return c;
   endfunction

   function automatic void clear_capture();
      rx_pos       = 0;
      crc_all      = '0;
      crc_msg      = '0;
      seen_dir     = '0;
      seen_dev     = '0;
      seen_rem     = '0;
      seen_plen    = '0;
      seen_type    = '0;
      seen_paylen  = '0;
      seen_msg_crc = '0;
      seen_pkt_crc = '0;
   endfunction

   function automatic kind_type classify_dispatch();
      if (seen_dev == DEV_KEYBOARD) begin
         if (seen_type == TYPE_BACKLIGHT) return KIND_KBD_BACKLIGHT;
         if (seen_type != TYPE_KBD) return KIND_KBD_BAD_TYPE;
         if (seen_paylen != KBD_PAYLOAD) return KIND_KBD_BAD_LEN;
         return KIND_KBD_REPORT;
      end
      if (seen_dev == DEV_TRACKPAD) begin
         if (seen_type == TYPE_MT_ENABLE) return KIND_MT_ENABLED;
         if (seen_type == TYPE_TOUCH) return KIND_TOUCH;
         return KIND_TPAD_BAD_TYPE;
      end
      if (seen_dev == DEV_SYSINFO)
         return (seen_type == TYPE_INFO) ? KIND_INFO : KIND_INFO_BAD_TYPE;
      return KIND_OTHER;
   endfunction

   // Advance the mirror by one accepted item; queue a verdict after the last byte
   function automatic void absorb_byte(input logic [7:0] b, input logic mark);
      int unsigned at, ofs;
      outcome_type r;
      if (mark) clear_capture();
      at = rx_pos;
      if (at >= PKT_BYTES) at = 0;
      if (at < PKT_BYTES - 2) crc_all = crc16_arc_byte(crc_all, b);
      case (at)
         POS_DIR:     seen_dir = b;
         POS_DEV:     seen_dev = b;
         POS_REM_LO:  seen_rem[7:0] = b;
         POS_REM_HI:  seen_rem[15:8] = b;
         POS_PLEN_LO: seen_plen[7:0] = b;
         POS_PLEN_HI: seen_plen[15:8] = b;
         default: ;
      endcase
      // Message area: header fields, message CRC and its stored copy
      if (at >= POS_DATA && at < POS_DATA + DATA_BYTES) begin
         ofs = at - POS_DATA;
         if (ofs + 2 < seen_plen) crc_msg = crc16_arc_byte(crc_msg, b);
         if (ofs == OFS_TYPE_LO) seen_type[7:0] = b;
         else if (ofs == OFS_TYPE_HI) seen_type[15:8] = b;
         else if (ofs == OFS_LEN_LO) seen_paylen[7:0] = b;
         else if (ofs == OFS_LEN_HI) seen_paylen[15:8] = b;
         else if (ofs == HDR_BYTES + seen_paylen) seen_msg_crc[7:0] = b;
         else if (ofs == HDR_BYTES + 1 + seen_paylen) seen_msg_crc[15:8] = b;
      end
      if (at == POS_PCRC_LO) seen_pkt_crc[7:0] = b;
      if (at == POS_LAST) seen_pkt_crc[15:8] = b;
      if (at != POS_LAST) begin
         rx_pos = at + 1;
         return;
      end
      // Verdict in priority order
      if (crc_all != seen_pkt_crc) r.status = ST_PKT_CRC;
      else if (seen_rem != 0) r.status = ST_MULTI;
      else if (int'(seen_paylen) + 10 >= DATA_BYTES) r.status = ST_TOO_LONG;
      else if (seen_plen < 2 || int'(seen_plen) - 2 > DATA_BYTES || seen_msg_crc != crc_msg)
         r.status = ST_MSG_CRC;
      else r.status = ST_OK;
      r.kind       = (r.status == ST_OK) ? classify_dispatch() : KIND_OTHER;
      r.device     = seen_dev;
      r.msg_type   = seen_type;
      r.msg_len    = seen_paylen;
      r.reply_done = (seen_dir == DIR_REPLY);
      expected_verdicts.push_back(r);
      rx_pos = 0;
   endfunction

   // Packet building
   function automatic void put16(input int at, input logic [15:0] v);
      frame[at]     = v[7:0];
      frame[at + 1] = v[15:8];
   endfunction

   function automatic void seal_packet();
      logic [15:0] c;
      c = '0;
      for (int i = 0; i < PKT_BYTES - 2; i++) c = crc16_arc_byte(c, frame[i]);
      put16(PKT_BYTES - 2, c);
   endfunction

   // Well-formed packet with random filler around the fields
   function automatic void compose_packet(input logic [7:0] dir, input logic [7:0] dev,
                                          input logic [15:0] mtype, input logic [15:0] paylen);
      logic [15:0] c;
      int          crc_at;
      for (int i = 0; i < PKT_BYTES; i++) frame[i] = 8'($urandom);
      frame[POS_DIR] = dir;
      frame[POS_DEV] = dev;
      put16(POS_REM_LO, 16'h0000);
      put16(POS_PLEN_LO, paylen + 16'd10);
      put16(POS_DATA + OFS_TYPE_LO, mtype);
      put16(POS_DATA + OFS_LEN_LO, paylen);
      crc_at = POS_DATA + HDR_BYTES + paylen;
      c = '0;
      for (int i = POS_DATA; i < crc_at && i < PKT_BYTES - 2; i++) c = crc16_arc_byte(c, frame[i]);
      if (crc_at + 1 < PKT_BYTES - 2) put16(crc_at, c);
      seal_packet();
   endfunction

   // Drive one item and wait for its handshake
   task automatic send_byte(input logic [7:0] value, input logic mark);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= mark;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      absorb_byte(value, mark);
   endtask

   task automatic send_frame(input int count, input logic mark);
      for (int i = 0; i < count; i++) send_byte(frame[i], mark && (i == 0));
   endtask

   task automatic send_clean(input logic [7:0] dir, input logic [7:0] dev,
                             input logic [15:0] mtype, input logic [15:0] paylen);
      compose_packet(dir, dev, mtype, paylen);
      send_frame(PKT_BYTES, 1'b1);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
   endtask

   // Every dispatch kind from a clean packet
   task automatic test_dispatch_kinds();
      send_clean(DIR_REPLY, DEV_KEYBOARD, TYPE_KBD, KBD_PAYLOAD);
      send_clean(8'h00, DEV_KEYBOARD, TYPE_BACKLIGHT, 16'd3);
      send_clean(8'h41, DEV_KEYBOARD, 16'hFFFF, KBD_PAYLOAD);
      send_clean(DIR_REPLY, DEV_KEYBOARD, TYPE_KBD, 16'd9);
      send_clean(8'hFF, DEV_TRACKPAD, TYPE_MT_ENABLE, 16'd0);
      send_clean(DIR_REPLY, DEV_TRACKPAD, TYPE_TOUCH, 16'd235);   // longest payload allowed
      send_clean(8'h3F, DEV_TRACKPAD, 16'h0000, 16'd20);
      send_clean(DIR_REPLY, DEV_SYSINFO, TYPE_INFO, 16'd40);
      send_clean(8'h80, DEV_SYSINFO, 16'h1021, 16'd1);
      send_clean(DIR_REPLY, 8'hFF, TYPE_KBD, KBD_PAYLOAD);
      send_clean(8'h00, 8'h00, TYPE_TOUCH, 16'd5);
   endtask

   // Each failing verdict, the length edge cases and constant-filled packets
   task automatic test_verdicts();
      compose_packet(DIR_REPLY, DEV_KEYBOARD, TYPE_KBD, KBD_PAYLOAD);
      frame[PKT_BYTES - 2] ^= 8'h01;
      send_frame(PKT_BYTES, 1'b1);
      compose_packet(DIR_REPLY, DEV_TRACKPAD, TYPE_TOUCH, 16'd30);
      frame[POS_REM_HI] = 8'h80;
      seal_packet();
      send_frame(PKT_BYTES, 1'b1);
      // payload one past the allowed maximum
      send_clean(DIR_REPLY, DEV_SYSINFO, TYPE_INFO, 16'd236);
      compose_packet(8'h00, DEV_KEYBOARD, TYPE_KBD, KBD_PAYLOAD);
      frame[POS_DATA + HDR_BYTES + KBD_PAYLOAD + 1] ^= 8'h80;
      seal_packet();
      send_frame(PKT_BYTES, 1'b1);
      // packet lengths below 2 and beyond the data area
      compose_packet(DIR_REPLY, DEV_KEYBOARD, TYPE_KBD, KBD_PAYLOAD);
      put16(POS_PLEN_LO, 16'd0);
      seal_packet();
      send_frame(PKT_BYTES, 1'b1);
      compose_packet(DIR_REPLY, DEV_TRACKPAD, TYPE_MT_ENABLE, 16'd0);
      put16(POS_PLEN_LO, 16'd1);
      seal_packet();
      send_frame(PKT_BYTES, 1'b1);
      compose_packet(DIR_REPLY, DEV_SYSINFO, TYPE_INFO, 16'd0);
      put16(POS_PLEN_LO, 16'd249);
      seal_packet();
      send_frame(PKT_BYTES, 1'b1);
      compose_packet(8'h00, DEV_TRACKPAD, TYPE_TOUCH, 16'd4);
      put16(POS_PLEN_LO, 16'hFFFF);
      seal_packet();
      send_frame(PKT_BYTES, 1'b1);
      // all zeros, then all ones
      for (int i = 0; i < PKT_BYTES; i++) frame[i] = 8'h00;
      send_frame(PKT_BYTES, 1'b1);
      for (int i = 0; i < PKT_BYTES; i++) frame[i] = 8'hFF;
      send_frame(PKT_BYTES, 1'b1);
   endtask

   // Packet with no first mark, and first marks that cut packets short
   task automatic test_framing();
      send_clean(DIR_REPLY, DEV_KEYBOARD, TYPE_KBD, KBD_PAYLOAD);
      compose_packet(DIR_REPLY, DEV_TRACKPAD, TYPE_TOUCH, 16'd12);
      send_frame(PKT_BYTES, 1'b0);
      compose_packet(DIR_REPLY, DEV_SYSINFO, TYPE_INFO, 16'd8);
      send_frame(100, 1'b1);
      compose_packet(8'h00, DEV_KEYBOARD, TYPE_BACKLIGHT, 16'd2);
      send_frame(PKT_BYTES - 1, 1'b1);
      send_clean(DIR_REPLY, DEV_TRACKPAD, TYPE_MT_ENABLE, 16'd6);
      // hold the sender until every verdict is out
      wait_drained();
      send_clean(8'h00, DEV_KEYBOARD, TYPE_KBD, KBD_PAYLOAD);
   endtask

   // Mostly well-formed packets with random content, some broken, some noise
   task automatic test_random_traffic(input int packets);
      int          pick, len;
      logic [7:0]  dev;
      logic [15:0] mtype, paylen;
      for (int n = 0; n < packets; n++) begin
         case ($urandom_range(3))
            0:       dev = DEV_KEYBOARD;
            1:       dev = DEV_TRACKPAD;
            2:       dev = DEV_SYSINFO;
            default: dev = 8'($urandom);
         endcase
         case ($urandom_range(5))
            0:       mtype = TYPE_KBD;
            1:       mtype = TYPE_BACKLIGHT;
            2:       mtype = TYPE_MT_ENABLE;
            3:       mtype = TYPE_TOUCH;
            4:       mtype = TYPE_INFO;
            default: mtype = 16'($urandom);
         endcase
         if ($urandom_range(1))
            paylen = (dev == DEV_KEYBOARD) ? KBD_PAYLOAD : 16'($urandom_range(0, 40));
         else
            paylen = 16'($urandom_range(0, 235));
         compose_packet($urandom_range(1) ? DIR_REPLY : 8'($urandom), dev, mtype, paylen);
         pick = $urandom_range(99);
         if (pick < 65) ;
         else if (pick < 70) frame[PKT_BYTES - 1 - $urandom_range(1)] ^= 8'($urandom_range(1, 255));
         else if (pick < 75) begin
            put16(POS_REM_LO, 16'($urandom_range(1, 16'hFFFF)));
            seal_packet();
         end else if (pick < 80) begin
            put16(POS_DATA + OFS_LEN_LO, 16'($urandom_range(236, 16'hFFFF)));
            seal_packet();
         end else if (pick < 85) begin
            frame[POS_DATA + HDR_BYTES + paylen + $urandom_range(1)] ^= 8'($urandom_range(1, 255));
            seal_packet();
         end else if (pick < 90) begin
            case ($urandom_range(3))
               0:       put16(POS_PLEN_LO, 16'($urandom_range(0, 1)));
               1:       put16(POS_PLEN_LO, 16'($urandom_range(249, 16'hFFFF)));
               2:       put16(POS_PLEN_LO, 16'($urandom_range(2, 248)));
               default: put16(POS_PLEN_LO, 16'hFFFF);
            endcase
            seal_packet();
         end
         if (pick < 94) send_frame(PKT_BYTES, 1'b1);
         else if (pick < 96) send_frame(PKT_BYTES, 1'b0);
         else if (pick < 98) send_frame($urandom_range(1, PKT_BYTES - 1), 1'b1);
         else begin
            len = $urandom_range(1, 30);
            for (int i = 0; i < len; i++) send_byte(8'($urandom), $urandom_range(3) == 0);
         end
      end
   endtask

   // Back-to-back items with the result side always ready
   task automatic test_full_rate();
      idle_pct  = 0;
      stall_pct = 0;
      test_random_traffic(6);
      idle_pct  = 35;
      stall_pct = 35;
   endtask

   // Hold the result side until the verdict queue pushes back on the input
   task automatic test_backpressure();
      bit sent_all;
      sent_all  = 1'b0;
      stall_pct = 100;
      fork
         begin
            for (int n = 0; n < 4; n++)
               send_clean(DIR_REPLY, DEV_TRACKPAD, TYPE_TOUCH, 16'($urandom_range(0, 30)));
            sent_all = 1'b1;
         end
         begin
            while (req_tready !== 1'b0 && !sent_all) @(posedge clock);
            stall_pct = 35;
         end
      join
   endtask

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endfunction

   // Result side: random stalls, compare each accepted verdict in order
   always @(posedge clock) begin : verdict_check
      outcome_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = outcome_type'(rsp_tdata);
         if (expected_verdicts.size() == 0) begin
            $error("verdict 0x%012h with none expected", rsp_tdata);
            failures++;
         end else begin
            want = expected_verdicts.pop_front();
            check_field("status", want.status, got.status);
            check_field("kind", want.kind, got.kind);
            check_field("device", want.device, got.device);
            check_field("msg_type", want.msg_type, got.msg_type);
            check_field("msg_len", want.msg_len, got.msg_len);
            check_field("reply_done", want.reply_done, got.reply_done);
         end
      end
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Sequence of tests
   initial begin
      clear_capture();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_dispatch_kinds();
      test_verdicts();
      test_framing();
      test_random_traffic(56);
      test_full_rate();
      test_backpressure();
      test_random_traffic(4);
      req_tvalid <= 1'b0;
      wait_drained();
      repeat (10) @(posedge clock);
      if (failures == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Watchdog
   initial begin
      #3_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### sim.f
hdl/rpcc_pkg.sv
hdl/rpcc_front.sv
hdl/rpcc_queue.sv
hdl/rpcc_back.sv
hdl/rx_packet_check_classify.sv
verif/rx_packet_check_classify_test.sv
